>>> design/lmts_pkg.sv
// Package for the LCD mode timing sequencer: mode codes, mode lengths,
// controller state type and controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package lmts_pkg;

  localparam int unsigned ElapsedW = 16;
  localparam int unsigned TotalW   = 17;
  localparam int unsigned LineW    = 8;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned StepW    = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ModeW-1:0] MODE_HBLANK   = 2'd0;
  localparam logic [ModeW-1:0] MODE_VBLANK   = 2'd1;
  localparam logic [ModeW-1:0] MODE_OAM      = 2'd2;
  localparam logic [ModeW-1:0] MODE_TRANSFER = 2'd3;

  localparam logic [TotalW-1:0] HBLANK_CYCLES      = 17'd204;
  localparam logic [TotalW-1:0] OAM_CYCLES         = 17'd80;
  localparam logic [TotalW-1:0] TRANSFER_CYCLES    = 17'd172;
  localparam logic [TotalW-1:0] VBLANK_LINE_CYCLES = 17'd456;

  localparam logic [StepW-1:0] VBLANK_LINES  = 4'd10;
  localparam logic [LineW-1:0] VISIBLE_LINES = 8'd144;
  localparam logic [LineW-1:0] LINE_CLAMP    = 8'd153;

  localparam logic [CfgIdxW-1:0] CFG_COMPARE_LINE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COINC_EN     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_VBLANK_EN    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_OAM_EN       = 2'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } lmts_state_e;

  typedef struct packed {
    logic load;     // start a new item: add elapsed cycles to leftover
    logic step;     // execute one mode action
    logic publish;  // move result into the output register
  } lmts_cmd_t;

  typedef struct packed {
    logic more;     // total exceeds current mode length
    logic out_free; // output register can take a result
  } lmts_status_t;

  function automatic logic [TotalW-1:0] mode_len(input logic [ModeW-1:0] m);
    logic [TotalW-1:0] len;
    case (m)
      MODE_HBLANK: len = HBLANK_CYCLES;
      MODE_VBLANK: len = VBLANK_LINE_CYCLES;
      MODE_OAM:    len = OAM_CYCLES;
      default:     len = TRANSFER_CYCLES;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> design/lmts_if.sv
// Handshake interfaces for the input and result channels.
// Depends on lmts_pkg.
`default_nettype none

interface lmts_in_if;
  logic                         valid;
  logic                         ready;
  logic [lmts_pkg::ElapsedW-1:0] elapsed_cycles;

  modport source (output valid, output elapsed_cycles, input ready);
  modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface lmts_out_if;
  logic                        valid;
  logic                        ready;
  logic                        vblank_request;
  logic                        stat_request;
  logic [lmts_pkg::ModeW-1:0]  display_mode;
  logic [lmts_pkg::LineW-1:0]  current_line;
  logic                        frame_done;

  modport source (output valid, output vblank_request, output stat_request,
                  output display_mode, output current_line, output frame_done,
                  input ready);
  modport sink   (input valid, input vblank_request, input stat_request,
                  input display_mode, input current_line, input frame_done,
                  output ready);
endinterface

`default_nettype wire

>>> design/lcd_mode_timing_sequencer.sv
// Top level of the LCD mode timing sequencer: controller plus datapath.
// Depends on lmts_pkg, lmts_if, lmts_ctrl, lmts_dp.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    elapsed_cycles[15:0]
//   out_o    out  valid/ready    vblank_request, stat_request, display_mode,
//                                current_line, frame_done
//   cfg      in   cfg_we_i       cfg_idx_i[1:0], cfg_data_i[7:0]
//
// An item is loaded, then the datapath step loop runs one mode action per cycle
// for each mode step it triggers; the result is published once the output is free.
// The result register holds a finished result while the next item is taken.
// A stalled result delays only the publish of the following item.
// Reset clears state, leftover and config registers.
`default_nettype none

module lcd_mode_timing_sequencer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  lmts_in_if.sink                           in_i,
  lmts_out_if.source                        out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [lmts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lmts_pkg::CfgDataW-1:0] cfg_data_i
);

  lmts_pkg::lmts_cmd_t    cmd;
  lmts_pkg::lmts_status_t status;
  logic                   vreq;

  lmts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lmts_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .elapsed_i    (in_i.elapsed_cycles),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .vblank_req_o (vreq),
    .stat_req_o   (out_o.stat_request),
    .mode_o       (out_o.display_mode),
    .line_o       (out_o.current_line)
  );

  assign out_o.vblank_request = vreq;
  assign out_o.frame_done     = vreq;

endmodule

`default_nettype wire

>>> design/lmts_ctrl.sv
// Controller FSM: accepts an item, steps the datapath while cycles remain,
// then hands the result to the output register. Depends on lmts_pkg.
`default_nettype none

module lmts_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire lmts_pkg::lmts_status_t status_i,
  output lmts_pkg::lmts_cmd_t        cmd_o
);

  lmts_pkg::lmts_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lmts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lmts_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lmts_pkg::ST_RUN;
      end
      lmts_pkg::ST_RUN: begin
        if (!status_i.more && status_i.out_free) state_d = lmts_pkg::ST_IDLE;
      end
      default: state_d = lmts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.publish = 1'b0;
    case (state_q)
      lmts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      lmts_pkg::ST_RUN: begin
        cmd_o.step    = status_i.more;
        cmd_o.publish = !status_i.more && status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> design/lmts_dp.sv
// Datapath: config registers, mode/line/leftover state, one mode action per
// step, and the result register. Depends on lmts_pkg.
`default_nettype none

module lmts_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lmts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lmts_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic [lmts_pkg::ElapsedW-1:0] elapsed_i,
  input  wire lmts_pkg::lmts_cmd_t          cmd_i,
  output lmts_pkg::lmts_status_t            status_o,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic                              vblank_req_o,
  output logic                              stat_req_o,
  output logic [lmts_pkg::ModeW-1:0]        mode_o,
  output logic [lmts_pkg::LineW-1:0]        line_o
);

  logic [lmts_pkg::LineW-1:0]  cmp_line_q;
  logic                        coinc_en_q, vbl_en_q, oam_en_q;

  logic [lmts_pkg::TotalW-1:0] total_q, total_d;
  logic [lmts_pkg::ModeW-1:0]  mode_q, mode_d;
  logic [lmts_pkg::LineW-1:0]  line_q, line_d;
  logic [lmts_pkg::StepW-1:0]  vcnt_q, vcnt_d;
  logic                        vreq_q, vreq_d, sreq_q, sreq_d;

  logic                        out_valid_q;
  logic                        out_vreq_q, out_sreq_q;
  logic [lmts_pkg::ModeW-1:0]  out_mode_q;
  logic [lmts_pkg::LineW-1:0]  out_line_q;

  logic [lmts_pkg::TotalW-1:0] len;
  logic [lmts_pkg::LineW-1:0]  line_inc;

  assign len      = lmts_pkg::mode_len(mode_q);
  assign line_inc = line_q + 8'd1;

  assign status_o.more     = total_q > len;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_line_q <= '0;
      coinc_en_q <= 1'b0;
      vbl_en_q   <= 1'b0;
      oam_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lmts_pkg::CFG_COMPARE_LINE: cmp_line_q <= cfg_data_i;
        lmts_pkg::CFG_COINC_EN:     coinc_en_q <= cfg_data_i[0];
        lmts_pkg::CFG_VBLANK_EN:    vbl_en_q   <= cfg_data_i[0];
        lmts_pkg::CFG_OAM_EN:       oam_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    total_d = total_q;
    mode_d  = mode_q;
    line_d  = line_q;
    vcnt_d  = vcnt_q;
    vreq_d  = vreq_q;
    sreq_d  = sreq_q;
    if (cmd_i.load) begin
      total_d = {1'b0, elapsed_i} + total_q;
      vreq_d  = 1'b0;
      sreq_d  = 1'b0;
    end else if (cmd_i.step) begin
      total_d = total_q - len;
      case (mode_q)
        lmts_pkg::MODE_HBLANK: begin
          if (line_q <= lmts_pkg::VISIBLE_LINES) begin
            if (coinc_en_q && line_q == cmp_line_q) sreq_d = 1'b1;
            line_d = line_inc;
          end
          if (line_d >= lmts_pkg::VISIBLE_LINES) begin
            mode_d = lmts_pkg::MODE_VBLANK;
            vreq_d = 1'b1;
            if (vbl_en_q) sreq_d = 1'b1;
          end else begin
            mode_d = lmts_pkg::MODE_OAM;
          end
        end
        lmts_pkg::MODE_VBLANK: begin
          if (vcnt_q >= lmts_pkg::VBLANK_LINES) begin
            mode_d = lmts_pkg::MODE_OAM;
            vcnt_d = '0;
            line_d = '0;
          end else begin
            line_d = line_inc;
            if (coinc_en_q && line_inc == cmp_line_q) sreq_d = 1'b1;
            vcnt_d = vcnt_q + 4'd1;
          end
          if (line_d > lmts_pkg::LINE_CLAMP) line_d = lmts_pkg::LINE_CLAMP;
        end
        lmts_pkg::MODE_OAM: begin
          if (oam_en_q) sreq_d = 1'b1;
          mode_d = lmts_pkg::MODE_TRANSFER;
        end
        default: mode_d = lmts_pkg::MODE_HBLANK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      mode_q  <= lmts_pkg::MODE_HBLANK;
      line_q  <= '0;
      vcnt_q  <= '0;
      vreq_q  <= 1'b0;
      sreq_q  <= 1'b0;
    end else begin
      total_q <= total_d;
      mode_q  <= mode_d;
      line_q  <= line_d;
      vcnt_q  <= vcnt_d;
      vreq_q  <= vreq_d;
      sreq_q  <= sreq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_vreq_q <= vreq_q;
      out_sreq_q <= sreq_q;
      out_mode_q <= mode_q;
      out_line_q <= line_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vblank_req_o = out_vreq_q;
  assign stat_req_o   = out_sreq_q;
  assign mode_o       = out_mode_q;
  assign line_o       = out_line_q;

endmodule

`default_nettype wire
